>>> hw/rtl/assert_macros.svh
// assertion helpers included by glmp_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while in reset
`define GLMP_ASSERT_IMP(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("glmp assertion failed");

// next-cycle implication, skipped while in reset
`define GLMP_ASSERT_NXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("glmp assertion failed");

`endif

>>> hw/rtl/glmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glmp_pkg
// shared types and constants of the longest monotone grid path block
// ----------------------------------------------------------------------------
package glmp_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int CELL_CAP = MAX_ROWS * MAX_COLS;
    localparam int IDX_W    = $clog2(CELL_CAP);
    localparam int CNT_W    = IDX_W + 1;
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int HGT_W    = 16;
    localparam int LEN_W    = 13;
    localparam int REG_W    = 7;

    typedef enum logic [0:0] {
        REG_ROW_COUNT    = 1'b0,
        REG_COLUMN_COUNT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [HGT_W-1:0] cell_height;
        logic             last_cell;
    } t_in_beat;

    typedef struct packed {
        logic [LEN_W-1:0] longest_path;
        logic             load_error;
    } t_out_beat;

    typedef struct packed {
        logic [REG_W-1:0] row_count;
        logic [REG_W-1:0] column_count;
    } t_cfg;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_pos;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CLEAR,
        S_START,
        S_START_W,
        S_TOP,
        S_TOP_W,
        S_NB,
        S_NB_W,
        S_FINISH,
        S_POP_W,
        S_NEXT,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/glmp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glmp_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module glmp_ram #(
    parameter int DATA_W = 16,
    parameter int ADDR_W = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/glmp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glmp_ctrl
// load sequencer and stack based grid walk over the height, memo and stack rams
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module glmp_ctrl
    import glmp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_beat         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_beat             o_out_data,
    // height ram
    output logic                  o_h_we,
    output logic [IDX_W-1:0]      o_h_waddr,
    output logic [HGT_W-1:0]      o_h_wdata,
    output logic [IDX_W-1:0]      o_h_raddr,
    input  wire logic [HGT_W-1:0] i_h_rdata,
    // memo ram
    output logic                  o_m_we,
    output logic [IDX_W-1:0]      o_m_waddr,
    output logic [LEN_W-1:0]      o_m_wdata,
    output logic [IDX_W-1:0]      o_m_raddr,
    input  wire logic [LEN_W-1:0] i_m_rdata,
    // stack ram
    output logic                  o_s_we,
    output logic [IDX_W-1:0]      o_s_waddr,
    output t_pos                  o_s_wdata,
    output logic [IDX_W-1:0]      o_s_raddr,
    input  wire t_pos             i_s_rdata
);

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_lc, n_lc;
    logic [CNT_W-1:0] r_cells, n_cells;
    logic [CNT_W-1:0] r_s, n_s;
    t_pos             r_spos, n_spos;
    logic [IDX_W-1:0] r_top, n_top;
    t_pos             r_pos, n_pos;
    logic [HGT_W-1:0] r_htop, n_htop;
    logic [1:0]       r_dir, n_dir;
    logic [LEN_W-1:0] r_len, n_len;
    logic [CNT_W-1:0] r_depth, n_depth;
    logic [IDX_W-1:0] r_nb, n_nb;
    t_pos             r_nbpos, n_nbpos;
    logic [LEN_W-1:0] r_best, n_best;
    t_out_beat        r_out, n_out;

    logic             nb_ok;
    logic [IDX_W-1:0] nb_idx;
    t_pos             nb_pos;
    logic [CNT_W-1:0] lc_inc;
    logic [2*REG_W-1:0] prod;
    logic             load_bad;
    logic [LEN_W-1:0] m_plus;

    always_comb begin
        nb_ok  = 1'b0;
        nb_idx = r_top;
        nb_pos = r_pos;
        case (r_dir)
            2'd0: begin
                nb_ok      = r_pos.col != '0;
                nb_idx     = r_top - IDX_W'(1);
                nb_pos.col = r_pos.col - COL_W'(1);
            end
            2'd1: begin
                nb_ok      = (REG_W'(r_pos.col) + REG_W'(1)) < i_cfg.column_count;
                nb_idx     = r_top + IDX_W'(1);
                nb_pos.col = r_pos.col + COL_W'(1);
            end
            2'd2: begin
                nb_ok      = r_pos.row != '0;
                nb_idx     = r_top - IDX_W'(i_cfg.column_count);
                nb_pos.row = r_pos.row - ROW_W'(1);
            end
            default: begin
                nb_ok      = (REG_W'(r_pos.row) + REG_W'(1)) < i_cfg.row_count;
                nb_idx     = r_top + IDX_W'(i_cfg.column_count);
                nb_pos.row = r_pos.row + ROW_W'(1);
            end
        endcase
    end

    assign lc_inc   = (r_lc <= CNT_W'(CELL_CAP)) ? r_lc + CNT_W'(1) : r_lc;
    assign prod     = i_cfg.row_count * i_cfg.column_count;
    assign load_bad = (i_cfg.row_count == '0) || (32'(i_cfg.row_count) > MAX_ROWS) ||
                      (i_cfg.column_count == '0) || (32'(i_cfg.column_count) > MAX_COLS) ||
                      ((2*REG_W)'(lc_inc) != prod);
    assign m_plus   = i_m_rdata + LEN_W'(1);

    always_comb begin
        n_state = r_state;
        n_lc    = r_lc;
        n_cells = r_cells;
        n_s     = r_s;
        n_spos  = r_spos;
        n_top   = r_top;
        n_pos   = r_pos;
        n_htop  = r_htop;
        n_dir   = r_dir;
        n_len   = r_len;
        n_depth = r_depth;
        n_nb    = r_nb;
        n_nbpos = r_nbpos;
        n_best  = r_best;
        n_out   = r_out;

        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        o_h_we      = 1'b0;
        o_h_waddr   = r_lc[IDX_W-1:0];
        o_h_wdata   = i_in_data.cell_height;
        o_h_raddr   = r_top;
        o_m_we      = 1'b0;
        o_m_waddr   = r_s[IDX_W-1:0];
        o_m_wdata   = '0;
        o_m_raddr   = r_s[IDX_W-1:0];
        o_s_we      = 1'b0;
        o_s_waddr   = r_depth[IDX_W-1:0];
        o_s_wdata   = r_spos;
        o_s_raddr   = '0;

        unique case (r_state)
            S_LOAD: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_h_we = r_lc < CNT_W'(CELL_CAP);
                    n_lc   = lc_inc;
                    if (i_in_data.last_cell) begin
                        n_lc    = '0;
                        n_best  = '0;
                        n_s     = '0;
                        n_spos  = '0;
                        n_cells = CNT_W'(prod);
                        if (load_bad) begin
                            n_out   = '{longest_path: '0, load_error: 1'b1};
                            n_state = S_OUT;
                        end else begin
                            n_state = S_CLEAR;
                        end
                    end
                end
            end
            S_CLEAR: begin
                o_m_we = 1'b1;
                if (r_s + CNT_W'(1) == r_cells) begin
                    n_s     = '0;
                    n_state = S_START;
                end else begin
                    n_s = r_s + CNT_W'(1);
                end
            end
            S_START: begin
                n_state = S_START_W;
            end
            S_START_W: begin
                if (i_m_rdata != '0) begin
                    if (i_m_rdata > r_best) begin
                        n_best = i_m_rdata;
                    end
                    n_state = S_NEXT;
                end else begin
                    o_s_we    = 1'b1;
                    o_s_waddr = '0;
                    o_s_wdata = r_spos;
                    n_depth   = CNT_W'(1);
                    n_top     = r_s[IDX_W-1:0];
                    n_pos     = r_spos;
                    n_state   = S_TOP;
                end
            end
            S_TOP: begin
                o_h_raddr = r_top;
                n_dir     = '0;
                n_len     = LEN_W'(1);
                n_state   = S_TOP_W;
            end
            S_TOP_W: begin
                n_htop  = i_h_rdata;
                n_state = S_NB;
            end
            S_NB: begin
                if (nb_ok) begin
                    o_h_raddr = nb_idx;
                    o_m_raddr = nb_idx;
                    n_nb      = nb_idx;
                    n_nbpos   = nb_pos;
                    n_state   = S_NB_W;
                end else if (r_dir == 2'd3) begin
                    n_state = S_FINISH;
                end else begin
                    n_dir = r_dir + 2'd1;
                end
            end
            S_NB_W: begin
                if (i_h_rdata > r_htop && i_m_rdata == '0) begin
                    o_s_we    = r_depth < CNT_W'(CELL_CAP);
                    o_s_wdata = r_nbpos;
                    if (r_depth < CNT_W'(CELL_CAP)) begin
                        n_depth = r_depth + CNT_W'(1);
                    end
                    n_top   = r_nb;
                    n_pos   = r_nbpos;
                    n_state = S_TOP;
                end else begin
                    if (i_h_rdata > r_htop && m_plus > r_len) begin
                        n_len = m_plus;
                    end
                    if (r_dir == 2'd3) begin
                        n_state = S_FINISH;
                    end else begin
                        n_dir   = r_dir + 2'd1;
                        n_state = S_NB;
                    end
                end
            end
            S_FINISH: begin
                o_m_we    = 1'b1;
                o_m_waddr = r_top;
                o_m_wdata = r_len;
                o_s_raddr = IDX_W'(r_depth - CNT_W'(2));
                n_depth   = r_depth - CNT_W'(1);
                if (r_depth == CNT_W'(1)) begin
                    if (r_len > r_best) begin
                        n_best = r_len;
                    end
                    n_state = S_NEXT;
                end else begin
                    n_state = S_POP_W;
                end
            end
            S_POP_W: begin
                n_pos   = i_s_rdata;
                n_top   = IDX_W'(i_s_rdata.row * i_cfg.column_count) + IDX_W'(i_s_rdata.col);
                n_state = S_TOP;
            end
            S_NEXT: begin
                n_s = r_s + CNT_W'(1);
                if (REG_W'(r_spos.col) + REG_W'(1) == i_cfg.column_count) begin
                    n_spos.col = '0;
                    n_spos.row = r_spos.row + ROW_W'(1);
                end else begin
                    n_spos.col = r_spos.col + COL_W'(1);
                end
                if (r_s + CNT_W'(1) == r_cells) begin
                    n_out   = '{longest_path: r_best, load_error: 1'b0};
                    n_state = S_OUT;
                end else begin
                    n_state = S_START;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc    <= '0;
            r_depth <= '0;
            r_best  <= '0;
        end else begin
            r_lc    <= n_lc;
            r_depth <= n_depth;
            r_best  <= n_best;
        end
        r_cells <= n_cells;
        r_s     <= n_s;
        r_spos  <= n_spos;
        r_top   <= n_top;
        r_pos   <= n_pos;
        r_htop  <= n_htop;
        r_dir   <= n_dir;
        r_len   <= n_len;
        r_nb    <= n_nb;
        r_nbpos <= n_nbpos;
        r_out   <= n_out;
    end

    assign o_out_data = r_out;

    `GLMP_ASSERT_IMP(a_err_zero, i_clk, i_rst_n,
        o_out_valid && o_out_data.load_error, o_out_data.longest_path == '0)
    `GLMP_ASSERT_IMP(a_depth_cap, i_clk, i_rst_n,
        1'b1, r_depth <= CNT_W'(CELL_CAP))
    `GLMP_ASSERT_NXT(a_last_stalls, i_clk, i_rst_n,
        r_state == S_LOAD && i_in_valid && i_in_data.last_cell, o_in_stall)
    `GLMP_ASSERT_IMP(a_walk_depth, i_clk, i_rst_n,
        r_state == S_TOP || r_state == S_NB || r_state == S_FINISH, r_depth != '0)

endmodule

`default_nettype wire

>>> hw/rtl/grid_longest_monotone_path.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_longest_monotone_path
// loads a height grid and reports its longest strictly rising neighbour path
// ----------------------------------------------------------------------------
// channel  direction  payload     handshake
// in       input      t_in_beat   i_in_valid / o_in_stall
// out      output     t_out_beat  o_out_valid / i_out_stall
// cfg      input      7-bit regs  i_cfg_we, no handshake back
//
// height beats load one per cycle into the height ram
// the last beat clears rows*columns memo entries and starts the walk;
// a bad load skips both and flags load_error; the walk is bound by the single
// read port of the height and memo rams; input stalls until the result leaves
// synchronous active-low reset; rams need no clearing after reset
module grid_longest_monotone_path
    import glmp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_beat         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_beat             o_out_data,
    input  wire logic             i_cfg_we,
    input  wire t_reg_idx         i_cfg_idx,
    input  wire logic [REG_W-1:0] i_cfg_data
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{row_count: REG_W'(1), column_count: REG_W'(1)};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROW_COUNT:    r_cfg.row_count    <= i_cfg_data;
                REG_COLUMN_COUNT: r_cfg.column_count <= i_cfg_data;
            endcase
        end
    end

    logic             h_we, m_we, s_we;
    logic [IDX_W-1:0] h_waddr, h_raddr, m_waddr, m_raddr, s_waddr, s_raddr;
    logic [HGT_W-1:0] h_wdata, h_rdata;
    logic [LEN_W-1:0] m_wdata, m_rdata;
    t_pos             s_wdata, s_rdata;

    glmp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_h_we      (h_we),
        .o_h_waddr   (h_waddr),
        .o_h_wdata   (h_wdata),
        .o_h_raddr   (h_raddr),
        .i_h_rdata   (h_rdata),
        .o_m_we      (m_we),
        .o_m_waddr   (m_waddr),
        .o_m_wdata   (m_wdata),
        .o_m_raddr   (m_raddr),
        .i_m_rdata   (m_rdata),
        .o_s_we      (s_we),
        .o_s_waddr   (s_waddr),
        .o_s_wdata   (s_wdata),
        .o_s_raddr   (s_raddr),
        .i_s_rdata   (s_rdata)
    );

    glmp_ram #(.DATA_W(HGT_W), .ADDR_W(IDX_W)) u_height (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    glmp_ram #(.DATA_W(LEN_W), .ADDR_W(IDX_W)) u_memo (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    glmp_ram #(.DATA_W($bits(t_pos)), .ADDR_W(IDX_W)) u_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

endmodule

`default_nettype wire

>>> dv/tb_grid_longest_monotone_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_longest_monotone_path
// self-checking bench for the longest monotone grid path block: grids are
// loaded under random valid/stall gaps, each result is checked against an
// in-bench memoised stack walk, with register errors and bad loads mixed in
// ----------------------------------------------------------------------------
module tb_grid_longest_monotone_path;
    import glmp_pkg::*;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    t_in_beat         i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_beat        o_out_data;
    logic             i_cfg_we = 1'b0;
    t_reg_idx         i_cfg_idx = REG_ROW_COUNT;
    logic [REG_W-1:0] i_cfg_data = '0;

    grid_longest_monotone_path DUT (.*);

    t_in_beat  pending_beats[$];
    t_out_beat expected_paths[$];

    logic [HGT_W-1:0] grid_heights[CELL_CAP];
    logic [LEN_W-1:0] memo_len[CELL_CAP];
    int unsigned      walk_stk[CELL_CAP];
    int unsigned      loaded_cells = 0;
    logic [REG_W-1:0] rows_reg = 1;
    logic [REG_W-1:0] cols_reg = 1;

    int  in_gap = 0;
    int  out_gap = 0;
    bit  no_idle = 0;
    int  errors = 0;
    int  mismatches = 0;
    int  beats_sent = 0;
    int  grids_seen = 0;
    int  error_results = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned longest_rise(int unsigned rows, int unsigned cols);
        int unsigned cells;
        int unsigned best;
        int unsigned depth;
        int unsigned top;
        int unsigned len;
        int unsigned nb;
        int unsigned r;
        int unsigned c;
        int unsigned d;
        bit          pushed;
        bit          ok;
        cells = rows * cols;
        best = 0;
        for (int i = 0; i < CELL_CAP; i++) memo_len[i] = '0;
        for (int unsigned s = 0; s < cells; s++) begin
            if (memo_len[s] == 0) begin
                depth = 1;
                walk_stk[0] = s;
                while (depth > 0) begin
                    top = walk_stk[depth-1];
                    r = top / cols;
                    c = top % cols;
                    len = 1;
                    pushed = 0;
                    d = 0;
                    while (d < 4 && !pushed) begin
                        ok = 1;
                        case (d)
                            0: if (c == 0) ok = 0; else nb = top - 1;
                            1: if (c + 1 >= cols) ok = 0; else nb = top + 1;
                            2: if (r == 0) ok = 0; else nb = top - cols;
                            default: if (r + 1 >= rows) ok = 0; else nb = top + cols;
                        endcase
                        if (ok && grid_heights[nb] > grid_heights[top]) begin
                            if (memo_len[nb] == 0) begin
                                walk_stk[depth] = nb;
                                depth++;
                                pushed = 1;
                            end else if (memo_len[nb] + 1 > len) begin
                                len = memo_len[nb] + 1;
                            end
                        end
                        d++;
                    end
                    if (!pushed) begin
                        memo_len[top] = len;
                        depth--;
                    end
                end
            end
            if (memo_len[s] > best) best = memo_len[s];
        end
        return best;
    endfunction

    task automatic predict_beat(t_in_beat b);
        t_out_beat res;
        bit        bad;
        if (loaded_cells < CELL_CAP) grid_heights[loaded_cells] = b.cell_height;
        if (loaded_cells <= CELL_CAP) loaded_cells++;
        if (b.last_cell) begin
            bad = rows_reg == 0 || rows_reg > MAX_ROWS || cols_reg == 0 ||
                  cols_reg > MAX_COLS || loaded_cells != rows_reg * cols_reg;
            res.load_error = bad;
            res.longest_path = bad ? '0 : LEN_W'(longest_rise(rows_reg, cols_reg));
            expected_paths.push_back(res);
            loaded_cells = 0;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        t_in_beat nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_beat(i_in_data);
                beats_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    nxt = pending_beats.pop_front();
                    i_in_data <= nxt;
                    i_in_valid <= 1'b1;
                    in_gap = no_idle ? 0 : $urandom_range(0, 6);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                grids_seen++;
                if (o_out_data.load_error) error_results++;
                if (expected_paths.size() == 0) begin
                    errors++;
                    $display("unexpected result beat: len %0d err %0b",
                             o_out_data.longest_path, o_out_data.load_error);
                end else begin
                    want = expected_paths.pop_front();
                    if (want.longest_path !== o_out_data.longest_path ||
                        want.load_error !== o_out_data.load_error) begin
                        errors++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp len %0d err %0b, got len %0d err %0b",
                                     want.longest_path, want.load_error,
                                     o_out_data.longest_path, o_out_data.load_error);
                    end
                end
                out_gap = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // sampled away from the rising edge so driver and monitor updates have settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_beats.size() != 0 || expected_paths.size() != 0 || i_in_valid);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [REG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_ROW_COUNT) rows_reg = val;
        else cols_reg = val;
    endtask

    task automatic set_grid(logic [REG_W-1:0] rows, logic [REG_W-1:0] cols);
        wait_idle();
        write_reg(REG_ROW_COUNT, rows);
        write_reg(REG_COLUMN_COUNT, cols);
    endtask

    // style: 0 narrow heights, 1 full range, 2 rising row-major, 3 extremes
    task automatic queue_grid(int n, int style);
        t_in_beat b;
        for (int i = 0; i < n; i++) begin
            case (style)
                0: b.cell_height = HGT_W'($urandom_range(0, 5));
                1: b.cell_height = HGT_W'($urandom);
                2: b.cell_height = HGT_W'(i);
                default: b.cell_height = ($urandom_range(0, 1) != 0) ? '1 : '0;
            endcase
            b.last_cell = (i == n - 1);
            pending_beats.push_back(b);
        end
    endtask

    initial begin
        int r;
        int c;
        int n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers give a 1x1 grid
        queue_grid(1, 3);
        set_grid(2, 2);
        queue_grid(4, 3);
        queue_grid(3, 0);
        queue_grid(5, 1);
        set_grid(0, 3);
        queue_grid(1, 0);
        set_grid(3, 0);
        queue_grid(1, 0);
        set_grid(65, 1);
        queue_grid(1, 0);
        set_grid(1, 127);
        queue_grid(1, 0);
        set_grid(1, 64);
        queue_grid(64, 2);
        set_grid(64, 1);
        queue_grid(64, 2);
        set_grid(64, 64);
        queue_grid(CELL_CAP, 1);
        queue_grid(CELL_CAP + 4, 0);

        while (beats_sent + pending_beats.size() < 1900 + 2 * CELL_CAP + 150) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) set_grid(7'($urandom_range(1, 16)),
                                                    7'($urandom_range(1, 16)));
            else set_grid(7'($urandom_range(1, 5)), 7'($urandom_range(1, 5)));
            if ($urandom_range(0, 29) == 0)
                write_reg($urandom_range(0, 1) ? REG_ROW_COUNT : REG_COLUMN_COUNT,
                          7'($urandom_range(0, 1) ? 0 : $urandom_range(65, 127)));
            r = rows_reg;
            c = cols_reg;
            repeat ($urandom_range(1, 3)) begin
                n = r * c;
                if ($urandom_range(0, 14) == 0) n = $urandom_range(1, n + 3);
                queue_grid(n, $urandom_range(0, 3));
            end
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        $display("%0d height beats loaded, %0d results checked (%0d flagged as load errors)",
                 beats_sent, grids_seen, error_results);
        $display("grids from 1x1 to 64x64, bad register values and short, long and overflow loads");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> grid_longest_monotone_path.f
+incdir+hw/rtl
hw/rtl/glmp_pkg.sv
hw/rtl/glmp_ram.sv
hw/rtl/glmp_ctrl.sv
hw/rtl/grid_longest_monotone_path.sv
dv/tb_grid_longest_monotone_path.sv
